// ===== hdl/masked_priority_interrupt_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the masked priority interrupt controller
// Shared property shapes, clocked on clk and idle while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_PRIORITY_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH
`define MASKED_PRIORITY_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication
`define MPIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MPIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mpic_pkg.sv =====
// ----------------------------------------------------------------------------
// mpic_pkg
// Types, field layout and constants of the masked priority interrupt controller.
// ----------------------------------------------------------------------------
package mpic_pkg;

    // Number of request sources
    localparam int NUM_SOURCES = 32;

    // Stream word widths
    localparam int MODE_W      = 3;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [APB_ADDR_W-1:0] CFG_ADDR_DEFAULT_LINE = 3'd0;

    // Input word layout (s_tdata)
    localparam int IN_SRC_LSB  = 0;
    localparam int IN_ADR_LSB  = 5;
    localparam int IN_SIZE_LSB = 37;
    localparam int IN_DAT_LSB  = 39;
    localparam int IN_LVL_LSB  = 71;

    // Output word layout (m_tdata)
    localparam int OUT_RDATA_LSB = 0;
    localparam int OUT_HIT_BIT   = 32;
    localparam int OUT_RAISE_BIT = 33;
    localparam int OUT_LINE_LSB  = 34;

    // Register window
    localparam logic [31:0] WIN_LAST     = 32'h0000_0010;
    localparam logic [4:0]  WIN_LINE_END = 5'h03;
    localparam logic [4:0]  WIN_PEND_END = 5'h07;
    localparam logic [4:0]  WIN_MASK_BEG = 5'h08;
    localparam logic [4:0]  WIN_MASK_END = 5'h0C;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_REQUEST = 3'd1,
        MODE_LOAD    = 3'd2,
        MODE_STORE   = 3'd3,
        MODE_RESET   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2,
        SIZE_WIDE = 2'd3
    } size_t;

    // Lowest set bit index; zero when the vector is empty
    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i])
                idx = 5'(i);
        end
        return idx;
    endfunction

endpackage

// ===== hdl/masked_priority_interrupt_controller_unit.sv =====
// ----------------------------------------------------------------------------
// masked_priority_interrupt_controller_unit: one result word per input word.
// One word per cycle while m_tready does not stall the result register.
// Input register, single-pass update of the register file, result register.
// Async reset clears valid flags and controller state; line returns to zero.
// ----------------------------------------------------------------------------
module masked_priority_interrupt_controller_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: source_id[4:0], address[36:5], access_size[38:37],
    //          write_data[70:39], reset_level[82:71], zero pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mpic_pkg::IN_TDATA_W-1:0]   s_tdata,
    // s_tuser: mode[2:0]
    input  logic [mpic_pkg::MODE_W-1:0]       s_tuser,
    // m_tdata: read_data[31:0], local_hit[32], raise_interrupt[33],
    //          interrupt_line[37:34], zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mpic_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpic_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mpic_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mpic_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import mpic_pkg::*;

    // Pipeline registers
    logic                    in_valid_reg, in_valid_next;
    logic [MODE_W-1:0]       in_mode_reg;
    logic [IN_TDATA_W-1:0]   in_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    // Controller state
    logic [3:0]  default_line_reg;
    logic [3:0]  line_reg, line_next;
    logic [31:0] pend_reg, pend_next;
    logic [31:0] mask_reg, mask_next;
    logic [4:0]  active_reg, active_next;

    logic        accept;
    logic        fire;
    logic        cfg_wr;

    // Unpacked input fields
    mode_t       mode;
    logic [4:0]  source_id;
    logic [31:0] address;
    size_t       access_size;
    logic [31:0] write_data;
    logic [11:0] reset_level;

    // Result fields
    logic [31:0] read_data;
    logic        local_hit;
    logic        raise_interrupt;
    logic [31:0] pend_tick;
    logic [31:0] pend_lane;
    logic [31:0] mask_lane;
    logic [31:0] mask_merge;
    logic [4:0]  shf;
    logic        rst_hit;

    // Handshake
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == CFG_ADDR_DEFAULT_LINE);
    assign prdata = (paddr == CFG_ADDR_DEFAULT_LINE)
                    ? {28'b0, default_line_reg} : '0;

    // Field unpack from the input register
    assign mode        = mode_t'(in_mode_reg);
    assign source_id   = in_data_reg[IN_SRC_LSB +: 5];
    assign address     = in_data_reg[IN_ADR_LSB +: 32];
    assign access_size = size_t'(in_data_reg[IN_SIZE_LSB +: 2]);
    assign write_data  = in_data_reg[IN_DAT_LSB +: 32];
    assign reset_level = in_data_reg[IN_LVL_LSB +: 12];

    // Lane extraction for pending and mask loads
    always_comb
    begin
        pend_lane = pend_reg;
        mask_lane = mask_reg;
        unique case (access_size)
            SIZE_BYTE:
            begin
                pend_lane = {24'b0, 8'(pend_reg >> {address[1:0], 3'b000})};
                mask_lane = {24'b0, 8'(mask_reg >> {address[1:0], 3'b000})};
            end
            SIZE_HALF:
            begin
                pend_lane = {16'b0, 16'(pend_reg >> {address[0], 4'b0000})};
                mask_lane = {16'b0, 16'(mask_reg >> {address[0], 4'b0000})};
            end
            SIZE_WORD, SIZE_WIDE:
            begin
                pend_lane = pend_reg;
                mask_lane = mask_reg;
            end
        endcase
    end

    // Lane merge for mask stores
    always_comb
    begin
        shf        = '0;
        mask_merge = write_data;
        unique case (access_size)
            SIZE_BYTE:
            begin
                shf        = {address[1:0], 3'b000};
                mask_merge = (mask_reg & ~(32'h0000_00FF << shf))
                             | ({24'b0, write_data[7:0]} << shf);
            end
            SIZE_HALF:
            begin
                shf        = {address[0], 4'b0000};
                mask_merge = (mask_reg & ~(32'h0000_FFFF << shf))
                             | ({16'b0, write_data[15:0]} << shf);
            end
            SIZE_WORD, SIZE_WIDE:
            begin
                shf        = '0;
                mask_merge = write_data;
            end
        endcase
    end

    assign pend_tick = pend_reg & ~mask_reg;
    assign rst_hit   = reset_level[10] || (reset_level[9:6] == line_reg);

    // Single-pass item evaluation
    always_comb
    begin
        line_next       = line_reg;
        pend_next       = pend_reg;
        mask_next       = mask_reg;
        active_next     = active_reg;
        read_data       = '0;
        local_hit       = 1'b0;
        raise_interrupt = 1'b0;
        unique case (mode)
            MODE_TICK:
            begin
                pend_next = pend_tick;
                if (pend_tick != '0)
                begin
                    active_next     = lowest_set(pend_tick);
                    raise_interrupt = 1'b1;
                end
            end
            MODE_REQUEST:
            begin
                if (int'(source_id) < NUM_SOURCES)
                    pend_next = pend_reg | (32'h1 << source_id);
            end
            MODE_LOAD:
            begin
                if (address <= WIN_LAST)
                begin
                    local_hit = 1'b1;
                    priority if (address[4:0] <= WIN_LINE_END)
                        read_data = {28'b0, line_reg};
                    else if (address[4:0] <= WIN_PEND_END)
                        read_data = pend_lane;
                    else if (address[4:0] <= WIN_MASK_END)
                        read_data = mask_lane;
                    else
                        read_data = {27'b0, active_reg};
                end
            end
            MODE_STORE:
            begin
                if (address <= WIN_LAST)
                begin
                    local_hit = 1'b1;
                    if (address[4:0] <= WIN_LINE_END)
                        line_next = write_data[3:0];
                    else if (address[4:0] >= WIN_MASK_BEG && address[4:0] <= WIN_MASK_END)
                        mask_next = mask_merge;
                end
            end
            MODE_RESET:
            begin
                if (rst_hit)
                begin
                    if (reset_level[11])
                        line_next = default_line_reg;
                    pend_next       = '0;
                    mask_next       = '0;
                    active_next     = '0;
                    raise_interrupt = 1'b1;
                end
            end
            default:
            begin
                line_next = line_reg;
            end
        endcase
        out_data_next = {2'b00,
                         (raise_interrupt ? line_next : 4'h0),
                         raise_interrupt,
                         local_hit,
                         read_data};
    end

    // Valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            default_line_reg <= '0;
            line_reg         <= '0;
            pend_reg         <= '0;
            mask_reg         <= '0;
            active_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
                default_line_reg <= pwdata[3:0];
            if (fire)
            begin
                line_reg   <= line_next;
                pend_reg   <= pend_next;
                mask_reg   <= mask_next;
                active_reg <= active_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_mode_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (fire)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/mpic_checker.sv =====
// ----------------------------------------------------------------------------
// mpic_checker
// Port-level checks on the interrupt controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "masked_priority_interrupt_controller_unit_defines.svh"

module mpic_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mpic_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import mpic_pkg::*;

    logic [31:0] rdata;
    logic        hit;
    logic        raise;
    logic [3:0]  line;

    assign rdata = m_tdata[OUT_RDATA_LSB +: 32];
    assign hit   = m_tdata[OUT_HIT_BIT];
    assign raise = m_tdata[OUT_RAISE_BIT];
    assign line  = m_tdata[OUT_LINE_LSB +: 4];

    // A stalled result word holds
    `MPIC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // Input stalls only behind a full output register
    `MPIC_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with empty output")

    // Read data only comes from a window hit
    `MPIC_ASSERT_NOW(a_rdata_hit, m_tvalid && (rdata != 32'h0), hit, "read data without window hit")

    // Line number is shown only with a raised interrupt
    `MPIC_ASSERT_NOW(a_line_raise, m_tvalid && !raise, line == 4'h0, "line number without raise")

endmodule

bind masked_priority_interrupt_controller_unit mpic_checker u_mpic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
